[rtl/core/qdcws_pkg.sv]
// ----------------------------------------------------------------------------
// QDC word sparsifier package
// Shared constants, command codes and the structs that pass between the
// channel store and the filter stage.
// ----------------------------------------------------------------------------
package qdcws_pkg;

  localparam int CHANNELS         = 256;
  localparam int HELD_PER_CHANNEL = 4;
  localparam int MAX_RESULTS      = 5;
  localparam int WORD_W           = 32;
  localparam int CH_W             = $clog2(CHANNELS);
  localparam int SLOT_W           = $clog2(HELD_PER_CHANNEL);
  localparam int CNT_W            = 3;
  localparam int RES_CNT_W        = $clog2(MAX_RESULTS + 1);
  localparam int CODE_W           = 6;

  localparam logic [CNT_W-1:0]  CNT_ZERO  = '0;
  localparam logic [CNT_W-1:0]  CNT_Q     = CNT_W'(2);
  localparam logic [CNT_W-1:0]  CNT_HELD  = CNT_W'(HELD_PER_CHANNEL);
  localparam logic [CNT_W-1:0]  COUNT_SAT = CNT_W'(5);
  localparam logic [SLOT_W-1:0] SLOT_FIRST = '0;
  localparam logic [SLOT_W-1:0] SLOT_Q     = SLOT_W'(2);

  localparam logic [CODE_W-1:0] CODE_MEAN   = 6'h37;
  localparam logic [CODE_W-1:0] CODE_DROP_A = 6'h32;
  localparam logic [CODE_W-1:0] CODE_DROP_B = 6'h33;
  localparam logic [CODE_W-1:0] CODE_DROP_C = 6'h34;
  localparam logic [CODE_W-1:0] CODE_PROC   = 6'h20;
  localparam logic [CODE_W-1:0] CODE_Q_MASK = 6'h30;
  localparam logic [CODE_W-1:0] CODE_Q      = 6'h20;

  localparam logic [1:0] MODE_KEEP_FIRST = 2'd0;
  localparam logic [1:0] MODE_HOLD       = 2'd1;
  localparam logic [1:0] MODE_PASS       = 2'd2;

  localparam logic REG_MODE = 1'b0;
  localparam logic REG_MASK = 1'b1;

  typedef enum logic [1:0] {
    CMD_FIRST_HDR = 2'd0,
    CMD_HDR       = 2'd1,
    CMD_DATA      = 2'd2,
    CMD_FLUSH     = 2'd3
  } cmd_t;

  typedef logic [HELD_PER_CHANNEL-1:0][WORD_W-1:0] row_t;
  typedef logic [MAX_RESULTS-1:0][WORD_W-1:0]      result_row_t;

  typedef struct packed {
    logic               st_we;
    logic               held_we;
    logic [CH_W-1:0]    ch;
    logic [SLOT_W-1:0]  slot;
    logic [WORD_W-1:0]  word;
    logic [CNT_W-1:0]   cnt;
    logic               pq;
  } chan_wr_t;

  typedef struct packed {
    logic [CNT_W-1:0] cnt;
    logic             pq;
    row_t             row;
  } chan_rd_t;

  function automatic logic [CH_W-1:0] chan_of(input logic [WORD_W-1:0] w);
    chan_of = {w[31:28], w[25:22]};
  endfunction

endpackage

[rtl/core/qdcws_store.sv]
// ----------------------------------------------------------------------------
// QDC word sparsifier channel store
// Per-channel counters, pulse flags and held words in synchronous memories,
// with per-channel valid bits for event clearing and write forwarding.
// ----------------------------------------------------------------------------
module qdcws_store (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       rd_en,
  input  logic [qdcws_pkg::CH_W-1:0] rd_ch,
  input  logic                       clear_all,
  input  qdcws_pkg::chan_wr_t        wr,
  output qdcws_pkg::chan_rd_t        rd
);
  import qdcws_pkg::*;

  logic [CNT_W:0]        st_mem [CHANNELS];
  row_t                  held_mem [CHANNELS];
  logic [CNT_W:0]        st_q;
  row_t                  held_q;
  logic [CH_W-1:0]       q_ch;
  logic [CHANNELS-1:0]   st_valid;
  logic                  fwd_st_valid;
  logic                  fwd_held_valid;
  logic [CH_W-1:0]       fwd_ch;
  logic [SLOT_W-1:0]     fwd_slot;
  logic [WORD_W-1:0]     fwd_word;
  logic [CNT_W-1:0]      fwd_cnt;
  logic                  fwd_pq;

  always_ff @(posedge clk) begin
    if (wr.st_we) begin
      st_mem[wr.ch] <= {wr.pq, wr.cnt};
    end
    if (wr.held_we) begin
      held_mem[wr.ch][wr.slot] <= wr.word;
    end
    if (rd_en) begin
      st_q     <= st_mem[rd_ch];
      held_q   <= held_mem[rd_ch];
      q_ch     <= rd_ch;
      fwd_ch   <= wr.ch;
      fwd_slot <= wr.slot;
      fwd_word <= wr.word;
      fwd_cnt  <= wr.cnt;
      fwd_pq   <= wr.pq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st_valid       <= '0;
      fwd_st_valid   <= 1'b0;
      fwd_held_valid <= 1'b0;
    end else begin
      if (clear_all) begin
        st_valid <= '0;
      end else if (wr.st_we) begin
        st_valid[wr.ch] <= 1'b1;
      end
      if (rd_en) begin
        fwd_st_valid   <= wr.st_we;
        fwd_held_valid <= wr.held_we;
      end
    end
  end

  always_comb begin
    rd.row = held_q;
    if (fwd_held_valid && fwd_ch == q_ch) begin
      rd.row[fwd_slot] = fwd_word;
    end
    if (fwd_st_valid && fwd_ch == q_ch) begin
      rd.cnt = fwd_cnt;
      rd.pq  = fwd_pq;
    end else if (st_valid[q_ch]) begin
      rd.cnt = st_q[CNT_W-1:0];
      rd.pq  = st_q[CNT_W];
    end else begin
      rd.cnt = CNT_ZERO;
      rd.pq  = 1'b0;
    end
  end

endmodule

[rtl/core/qdcws_out_buf.sv]
// ----------------------------------------------------------------------------
// QDC word sparsifier output buffer
// Holds the result words of one input item and hands them out one per
// transfer, marking the last one.
// ----------------------------------------------------------------------------
module qdcws_out_buf (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            load,
  input  logic [qdcws_pkg::RES_CNT_W-1:0] load_n,
  input  qdcws_pkg::result_row_t          load_w,
  output logic                            free,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [qdcws_pkg::WORD_W-1:0]    out_word,
  output logic                            last_of_run
);
  import qdcws_pkg::*;

  result_row_t           buf_w;
  logic [RES_CNT_W-1:0]  buf_n;
  logic                  out_fire;

  assign out_valid   = (buf_n != '0);
  assign out_word    = buf_w[0];
  assign last_of_run = (buf_n == RES_CNT_W'(1));
  assign out_fire    = out_valid && out_ready;
  assign free        = (buf_n == '0) || (last_of_run && out_ready);

  always_ff @(posedge clk) begin
    if (rst) begin
      buf_n <= '0;
    end else if (load) begin
      buf_n <= load_n;
    end else if (out_fire) begin
      buf_n <= buf_n - RES_CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      buf_w <= load_w;
    end else if (out_fire) begin
      for (int i = 0; i < MAX_RESULTS - 1; i++) begin
        buf_w[i] <= buf_w[i + 1];
      end
    end
  end

endmodule

[rtl/core/qdc_word_sparsifier_unit.sv]
// ----------------------------------------------------------------------------
// QDC word sparsifier
// Per-event filter for a stream of 32-bit QDC words with held-word recovery.
// ----------------------------------------------------------------------------
// The unit accepts one item per clock cycle unless the filter stage is held
// by a busy output buffer. An accepted item starts a read of its channel's
// state and held words, and in the cycle after it the filter stage decides the
// results and, once it can pass them on, writes the channel back; a write from
// the previous item is forwarded to the next one, so items on the same channel
// may follow each other in consecutive cycles. An item passes the filter stage
// register and then the output buffer before its first result. The results of
// an item leave one per cycle while out_ready is high, and a five-word burst
// can hold back the following input. A first header clears the counters and
// pulse flags of all channels together; there is no clearing pass after reset.
module qdc_word_sparsifier_unit (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [2:0]                   paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [1:0]                   command,
  input  logic [qdcws_pkg::WORD_W-1:0] data_word,
  input  logic [7:0]                   flush_channel,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [qdcws_pkg::WORD_W-1:0] out_word,
  output logic                         last_of_run
);
  import qdcws_pkg::*;

  logic [1:0]            mode;
  logic [15:0]           module_mask;
  logic                  in_fire;
  logic [CH_W-1:0]       in_ch;
  logic                  p_valid;
  cmd_t                  p_cmd;
  logic [WORD_W-1:0]     p_d;
  logic [CH_W-1:0]       p_ch;
  logic                  p_fire;
  logic [RES_CNT_W-1:0]  p_n;
  result_row_t           p_w;
  logic                  p_clear;
  chan_wr_t              p_wr;
  chan_wr_t              wr;
  chan_rd_t              cur;
  logic                  buf_free;
  logic [3:0]            addr;
  logic [CODE_W-1:0]     code;
  logic                  filt;
  logic [CNT_W-1:0]      cnt_bump;

  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode        <= MODE_PASS;
      module_mask <= '0;
    end else if (psel && penable && pwrite) begin
      unique case (paddr[2])
        REG_MODE: mode        <= pwdata[1:0];
        REG_MASK: module_mask <= pwdata[15:0];
        default:  mode        <= mode;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_MODE: prdata = {30'b0, mode};
      REG_MASK: prdata = {16'b0, module_mask};
      default:  prdata = '0;
    endcase
  end

  assign in_ch    = (cmd_t'(command) == CMD_FLUSH) ? flush_channel : chan_of(data_word);
  assign p_fire   = p_valid && (p_n == '0 || buf_free);
  assign in_ready = !p_valid || p_fire;
  assign in_fire  = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      p_valid <= 1'b0;
    end else if (in_ready) begin
      p_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      p_cmd <= cmd_t'(command);
      p_d   <= data_word;
      p_ch  <= in_ch;
    end
  end

  qdcws_store u_store (
    .clk       (clk),
    .rst       (rst),
    .rd_en     (in_fire),
    .rd_ch     (in_ch),
    .clear_all (p_fire && p_clear),
    .wr        (wr),
    .rd        (cur)
  );

  assign addr     = p_d[31:28];
  assign code     = p_d[21:16];
  assign filt     = (mode == MODE_KEEP_FIRST || mode == MODE_HOLD) && module_mask[addr]
                    && ((code & CODE_PROC) != '0);
  assign cnt_bump = (cur.cnt < COUNT_SAT) ? cur.cnt + CNT_W'(1) : cur.cnt;

  always_comb begin
    p_n          = '0;
    p_w          = '0;
    p_w[0]       = p_d;
    p_clear      = 1'b0;
    p_wr.st_we   = 1'b0;
    p_wr.held_we = 1'b0;
    p_wr.ch      = p_ch;
    p_wr.slot    = SLOT_FIRST;
    p_wr.word    = p_d;
    p_wr.cnt     = cur.cnt;
    p_wr.pq      = cur.pq;
    unique case (p_cmd)
      CMD_FIRST_HDR: begin
        p_clear = 1'b1;
        p_n     = RES_CNT_W'(1);
      end
      CMD_HDR: begin
        p_n = RES_CNT_W'(1);
      end
      CMD_DATA: begin
        if (!filt) begin
          p_n = RES_CNT_W'(1);
        end else if ((code & CODE_Q_MASK) == CODE_Q) begin
          if (mode == MODE_KEEP_FIRST) begin
            p_n = RES_CNT_W'(1);
          end else if (cur.cnt == CNT_Q) begin
            p_wr.held_we = 1'b1;
            p_wr.slot    = SLOT_Q;
            p_wr.st_we   = 1'b1;
            p_wr.cnt     = cnt_bump;
          end else begin
            p_wr.st_we = 1'b1;
            p_wr.pq    = 1'b1;
            p_n        = RES_CNT_W'(1);
          end
        end else if (code == CODE_MEAN) begin
          if (cur.cnt < CNT_HELD) begin
            p_wr.held_we = 1'b1;
            p_wr.slot    = cur.cnt[SLOT_W-1:0];
          end
          p_wr.st_we = 1'b1;
          p_wr.cnt   = cnt_bump;
          if (mode == MODE_KEEP_FIRST) begin
            if (cur.cnt == CNT_ZERO) begin
              p_n = RES_CNT_W'(1);
            end
          end else if (cur.cnt == CNT_HELD) begin
            for (int i = 0; i < HELD_PER_CHANNEL; i++) begin
              p_w[i] = cur.row[i];
            end
            p_w[HELD_PER_CHANNEL] = p_d;
            p_n = RES_CNT_W'(MAX_RESULTS);
          end else if (cur.cnt > CNT_HELD) begin
            p_n = RES_CNT_W'(1);
          end
        end else if (code == CODE_DROP_A || code == CODE_DROP_B || code == CODE_DROP_C) begin
          p_n = '0;
        end else begin
          p_n = RES_CNT_W'(1);
        end
      end
      CMD_FLUSH: begin
        if (mode == MODE_HOLD && cur.cnt == CNT_HELD) begin
          p_w[0] = cur.row[SLOT_FIRST];
          p_w[1] = cur.row[SLOT_Q];
          p_n    = cur.pq ? RES_CNT_W'(1) : RES_CNT_W'(2);
        end
      end
      default: begin
        p_n = '0;
      end
    endcase
  end

  always_comb begin
    wr         = p_wr;
    wr.st_we   = p_wr.st_we && p_fire;
    wr.held_we = p_wr.held_we && p_fire;
  end

  qdcws_out_buf u_out_buf (
    .clk         (clk),
    .rst         (rst),
    .load        (p_fire && p_n != '0),
    .load_n      (p_n),
    .load_w      (p_w),
    .free        (buf_free),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .last_of_run (last_of_run)
  );

  a_burst_src: assert property (@(posedge clk) disable iff (rst)
    p_fire && p_n == RES_CNT_W'(MAX_RESULTS) |-> p_cmd == CMD_DATA && cur.cnt == CNT_HELD)
    else $error("five-word burst without a full held channel");

  a_flush_src: assert property (@(posedge clk) disable iff (rst)
    p_fire && p_cmd == CMD_FLUSH |-> p_n == '0 || (mode == MODE_HOLD && cur.cnt == CNT_HELD))
    else $error("flush emitted words outside the held state");

  a_stage_hold: assert property (@(posedge clk) disable iff (rst)
    p_valid && !p_fire |=> p_valid && $stable(p_d) && $stable(p_cmd) && $stable(p_ch))
    else $error("filter stage lost a stalled item");

  a_accept_fill: assert property (@(posedge clk) disable iff (rst)
    in_fire |=> p_valid)
    else $error("accepted transfer did not reach the filter stage");

endmodule

[dv/tb.sv]
// ----------------------------------------------------------------------------
// QDC word sparsifier testbench
// Drives headers, data words and flush commands through the unit under every
// mode and a range of module masks. A predictor with its own channel counters,
// pulse-Q flags and held words builds the expected output stream, and every
// output transfer is checked against it. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb;
  import qdcws_pkg::*;

  localparam logic [1:0]  MODE_UNDEF  = 2'd3;
  localparam logic [5:0]  CODE_OTHER  = 6'h3f;
  localparam logic [5:0]  CODE_RAW    = 6'h05;
  localparam int          IDLE_CYCLES = 12;

  typedef struct {
    logic [31:0] word;
    logic        last;
  } out_beat_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  cmd_t        command = CMD_HDR;
  logic [31:0] data_word = '0;
  logic [7:0]  flush_channel = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_word;
  logic        last_of_run;

  logic [1:0]  cur_mode = MODE_PASS;
  logic [15:0] cur_mask = '0;
  logic [31:0] held_words [CHANNELS*HELD_PER_CHANNEL];
  logic [2:0]  mean_count [CHANNELS];
  logic        pulse_q_seen [CHANNELS];
  out_beat_t   expected_beats [$];
  logic [7:0]  chan_pool [3];
  bit          no_gaps = 1'b0;
  int          mismatches = 0;

  qdc_word_sparsifier_unit uut (
    .clk(clk),
    .rst(rst),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .command(command),
    .data_word(data_word),
    .flush_channel(flush_channel),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_word(out_word),
    .last_of_run(last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #3000000;
    $display("FAILURE");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 55) begin
      return 0;
    end else if (r < 90) begin
      return $urandom_range(3, 1);
    end
    return $urandom_range(30, 8);
  endfunction

  function automatic void clear_event();
    for (int k = 0; k < CHANNELS; k++) begin
      mean_count[k] = '0;
      pulse_q_seen[k] = 1'b0;
    end
  endfunction

  function automatic void filter_data(input logic [31:0] w, ref logic [31:0] res [$]);
    logic [3:0] mdl;
    logic [7:0] ch;
    logic [5:0] code;
    logic [2:0] cnt;
    mdl = w[31:28];
    ch = {mdl, w[25:22]};
    code = w[21:16];
    cnt = mean_count[ch];
    if ((cur_mode != MODE_KEEP_FIRST && cur_mode != MODE_HOLD) || !cur_mask[mdl]) begin
      res.push_back(w);
    end else if ((code & CODE_PROC) == '0) begin
      res.push_back(w);
    end else if ((code & CODE_Q_MASK) == CODE_Q) begin
      if (cur_mode == MODE_KEEP_FIRST) begin
        res.push_back(w);
      end else if (cnt == CNT_Q) begin
        held_words[{ch, SLOT_Q}] = w;
        if (cnt < COUNT_SAT) mean_count[ch] = cnt + 1'b1;
      end else begin
        pulse_q_seen[ch] = 1'b1;
        res.push_back(w);
      end
    end else if (code == CODE_MEAN) begin
      if (cnt < CNT_HELD) held_words[{ch, cnt[SLOT_W-1:0]}] = w;
      if (cur_mode == MODE_KEEP_FIRST) begin
        if (cnt == CNT_ZERO) res.push_back(w);
      end else if (cnt >= CNT_HELD) begin
        if (cnt == CNT_HELD) begin
          for (int k = 0; k < HELD_PER_CHANNEL; k++) begin
            res.push_back(held_words[{ch, SLOT_W'(k)}]);
          end
        end
        res.push_back(w);
      end
      if (cnt < COUNT_SAT) mean_count[ch] = cnt + 1'b1;
    end else if (code != CODE_DROP_A && code != CODE_DROP_B && code != CODE_DROP_C) begin
      res.push_back(w);
    end
  endfunction

  function automatic void predict_sparsify(input cmd_t c, input logic [31:0] w,
                                           input logic [7:0] fc);
    logic [31:0] res [$];
    case (c)
      CMD_FIRST_HDR: begin
        clear_event();
        res.push_back(w);
      end
      CMD_HDR: begin
        res.push_back(w);
      end
      CMD_DATA: begin
        filter_data(w, res);
      end
      default: begin
        if (cur_mode == MODE_HOLD && mean_count[fc] == CNT_HELD) begin
          res.push_back(held_words[{fc, SLOT_FIRST}]);
          if (!pulse_q_seen[fc]) res.push_back(held_words[{fc, SLOT_Q}]);
        end
      end
    endcase
    foreach (res[k]) begin
      expected_beats.push_back('{word: res[k], last: (k == res.size() - 1)});
    end
  endfunction

  function automatic logic [31:0] qword(input logic [3:0] mdl, input logic [3:0] sub,
                                        input logic [5:0] code);
    return {mdl, 2'($urandom_range(3)), sub, code, 16'($urandom)};
  endfunction

  always @(posedge clk) begin
    out_beat_t exp_b;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $error("out_word: no result expected, actual %h", out_word);
        mismatches++;
      end else begin
        exp_b = expected_beats.pop_front();
        if (out_word !== exp_b.word) begin
          $error("out_word: expected %h, actual %h", exp_b.word, out_word);
          mismatches++;
        end
        if (last_of_run !== exp_b.last) begin
          $error("last_of_run: expected %b, actual %b", exp_b.last, last_of_run);
          mismatches++;
        end
      end
    end
  end

  initial begin
    forever begin
      if (no_gaps) begin
        out_ready <= 1'b1;
        @(posedge clk);
      end else begin
        out_ready <= ($urandom_range(99) < 70);
        repeat (pick_gap() + 1) @(posedge clk);
      end
    end
  end

  task automatic send_item(input cmd_t c, input logic [31:0] w, input logic [7:0] fc);
    int gap;
    gap = no_gaps ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= c;
    data_word <= w;
    flush_channel <= fc;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_sparsify(c, w, fc);
  endtask

  task automatic send_data(input logic [31:0] w);
    send_item(CMD_DATA, w, 8'($urandom));
  endtask

  task automatic send_flush(input logic [7:0] fc);
    send_item(CMD_FLUSH, $urandom, fc);
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (IDLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [31:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (sel == REG_MODE) begin
      cur_mode = value[1:0];
    end else begin
      cur_mask = value[15:0];
    end
    @(posedge clk);
  endtask

  task automatic configure(input logic [1:0] mode_val, input logic [15:0] mask_val);
    wait_idle();
    write_reg(REG_MODE, {30'd0, mode_val});
    write_reg(REG_MASK, {16'd0, mask_val});
  endtask

  task automatic test_reset_state();
    send_item(CMD_FIRST_HDR, 32'h0000_0000, 8'h00);
    send_data(32'hffff_ffff);
    send_flush(8'hff);
  endtask

  task automatic test_hold_recovery();
    configure(MODE_HOLD, 16'hffff);
    send_item(CMD_FIRST_HDR, $urandom, 8'hff);
    send_data(qword(4'hf, 4'hf, CODE_MEAN));
    send_data(qword(4'hf, 4'hf, CODE_MEAN));
    send_data(qword(4'hf, 4'hf, CODE_Q | 6'h0a));
    send_data(qword(4'hf, 4'hf, CODE_MEAN));
    send_flush(8'hff);
    send_flush(8'hff);
    send_data(qword(4'hf, 4'hf, CODE_MEAN));
    send_data(qword(4'hf, 4'hf, CODE_MEAN));
    send_data(qword(4'h0, 4'h0, CODE_Q));
    repeat (4) send_data(qword(4'h0, 4'h0, CODE_MEAN));
    send_flush(8'h00);
  endtask

  task automatic test_keep_first();
    configure(MODE_KEEP_FIRST, 16'hffff);
    send_item(CMD_HDR, $urandom, 8'h00);
    send_data(qword(4'h3, 4'h5, CODE_MEAN));
    send_data(qword(4'h3, 4'h5, CODE_MEAN));
    send_data(qword(4'h3, 4'h5, CODE_DROP_A));
    send_data(qword(4'h3, 4'h5, CODE_DROP_B));
    send_data(qword(4'h3, 4'h5, CODE_DROP_C));
    send_data(qword(4'h3, 4'h5, CODE_OTHER));
    send_data(qword(4'h3, 4'h5, CODE_RAW));
  endtask

  task automatic test_undefined_mode();
    configure(MODE_UNDEF, 16'hffff);
    send_data(qword(4'h0, 4'h0, CODE_MEAN));
    send_flush(8'h00);
  endtask

  task automatic random_phase(input logic [1:0] mode_val, input logic [15:0] mask_val,
                              input int items, input bit new_event, input bit new_pool);
    logic [3:0] mdl;
    logic [5:0] code;
    int r;
    configure(mode_val, mask_val);
    if (new_pool) begin
      foreach (chan_pool[p]) begin
        mdl = 4'($urandom_range(15));
        for (int k = 0; k < 16 && !mask_val[mdl]; k++) mdl = 4'($urandom_range(15));
        chan_pool[p] = {mdl, 4'($urandom_range(15))};
      end
    end
    for (int i = 0; i < items; i++) begin
      r = $urandom_range(99);
      if ((i == 0 && new_event) || r < 4) begin
        send_item(CMD_FIRST_HDR, $urandom, 8'($urandom));
      end else if (r < 9) begin
        send_item(CMD_HDR, $urandom, 8'($urandom));
      end else if (r < 22) begin
        send_flush(($urandom_range(99) < 80) ? chan_pool[$urandom_range(2)]
                                             : 8'($urandom));
      end else if (r < 28) begin
        send_data($urandom);
      end else begin
        r = $urandom_range(99);
        if (r < 45) begin
          code = CODE_MEAN;
        end else if (r < 60) begin
          code = CODE_Q | 6'($urandom_range(15));
        end else if (r < 72) begin
          code = CODE_DROP_A + 6'($urandom_range(2));
        end else if (r < 82) begin
          code = CODE_Q_MASK | 6'($urandom_range(15));
        end else begin
          code = 6'($urandom_range(31));
        end
        mdl = chan_pool[$urandom_range(2)][7:4];
        send_data(qword(mdl, chan_pool[$urandom_range(2)][3:0], code));
      end
    end
  endtask

  task automatic test_random_events();
    random_phase(MODE_HOLD, 16'hffff, 16, 1'b1, 1'b1);
    random_phase(MODE_KEEP_FIRST, 16'hffff, 12, 1'b1, 1'b1);
    random_phase(MODE_HOLD, 16'hffff, 12, 1'b0, 1'b0);
    no_gaps = 1'b1;
    random_phase(MODE_HOLD, 16'($urandom), 12, 1'b1, 1'b1);
    no_gaps = 1'b0;
    random_phase(MODE_KEEP_FIRST, 16'($urandom), 10, 1'b1, 1'b1);
    random_phase(MODE_PASS, 16'($urandom), 8, 1'b0, 1'b1);
    random_phase(MODE_UNDEF, 16'hffff, 6, 1'b0, 1'b1);
    random_phase(MODE_HOLD, 16'h0000, 6, 1'b1, 1'b1);
    random_phase(MODE_HOLD, 16'hffff, 10, 1'b1, 1'b1);
  endtask

  initial begin
    clear_event();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_reset_state();
    test_hold_recovery();
    test_keep_first();
    test_undefined_mode();
    test_random_events();
    wait_idle();
    repeat (IDLE_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[qdc_word_sparsifier_unit.f]
rtl/core/qdcws_pkg.sv
rtl/core/qdcws_store.sv
rtl/core/qdcws_out_buf.sv
rtl/core/qdc_word_sparsifier_unit.sv
dv/tb.sv
